// ===== src/lprt_pkg.sv =====
// ----------------------------------------------------------------------------
// lprt_pkg
// Shared constants, types and helpers for the longest-prefix route table.
// ----------------------------------------------------------------------------
`default_nettype none

package lprt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NOMATCH = 2'd2;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  length;
    logic [31:0] hop;
    logic [7:0]  port;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // lengths above 32 compare all 32 bits
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'h0;
    end else if (len > 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = 32'hFFFF_FFFF << (6'd32 - len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== src/lprt_in_if.sv =====
// ----------------------------------------------------------------------------
// lprt_in_if
// Request channel: operation code and route / destination fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface lprt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] prefix_addr;
  logic [5:0]  route_len;
  logic [31:0] route_gw;
  logic [7:0]  route_port;
  logic [31:0] dst_addr;

  modport source (output valid, func, prefix_addr, route_len, route_gw, route_port,
                  dst_addr, input ready);
  modport sink (input valid, func, prefix_addr, route_len, route_gw, route_port,
                dst_addr, output ready);
endinterface

`default_nettype wire

// ===== src/lprt_out_if.sv =====
// ----------------------------------------------------------------------------
// lprt_out_if
// Result channel: status, the matched route and its hit count.
// ----------------------------------------------------------------------------
`default_nettype none

interface lprt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_gw;
  logic [7:0]  found_iface;
  logic [31:0] hit_total;

  modport source (output valid, status, found_gw, found_iface, hit_total,
                  input ready);
  modport sink (input valid, status, found_gw, found_iface, hit_total,
                output ready);
endinterface

`default_nettype wire

// ===== src/lprt_ram.sv =====
// ----------------------------------------------------------------------------
// lprt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lprt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/longest_prefix_route_table_top.sv =====
// ----------------------------------------------------------------------------
// longest_prefix_route_table_top
// IPv4 route table: add, delete, longest-prefix lookup with hit counts, clear.
// ----------------------------------------------------------------------------
// Add and clear go from the request transfer to ST_FINISH, which loads the result once free.
// Delete and lookup scan the slots filled since the last clear, one table RAM read
//   per cycle; a matched lookup then reads the winner's route and hit count (ST_HITRD).
// One request in flight; the next transfer can come in the cycle after the result is loaded.
// Reset (sync, active low) clears the fill count and active bits; no clearing pass.
`default_nettype none

module longest_prefix_route_table_top
  import lprt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  lprt_in_if.sink     in_ch,
  lprt_out_if.source  out_ch
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_HITRD  = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       used_r, used_nxt;
  logic [TABLE_DEPTH-1:0] active_r, active_nxt;

  logic [1:0]  func_r, func_nxt;
  logic [31:0] paddr_r, paddr_nxt;
  logic [5:0]  plen_r, plen_nxt;
  logic [31:0] dst_r, dst_nxt;

  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] eval_idx_r, eval_idx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic [5:0]       best_len_r, best_len_nxt;

  logic [1:0]  res_status_r, res_status_nxt;
  logic [31:0] res_hop_r, res_hop_nxt;
  logic [7:0]  res_port_r, res_port_nxt;
  logic [31:0] res_hits_r, res_hits_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [31:0] out_hop_r, out_hop_nxt;
  logic [7:0]  out_port_r, out_port_nxt;
  logic [31:0] out_hits_r, out_hits_nxt;

  logic               acc;
  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_raddr;
  logic [ENTRY_W-1:0] tbl_rdata;
  entry_t             tbl_wentry;
  entry_t             ent;
  logic               hits_we;
  logic [IDX_W-1:0]   hits_waddr;
  logic [31:0]        hits_wdata;
  logic [IDX_W-1:0]   hits_raddr;
  logic [31:0]        hits_rdata;
  logic               is_hit;
  logic               scan_done;
  logic               out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_gw    = out_hop_r;
  assign out_ch.found_iface = out_port_r;
  assign out_ch.hit_total   = out_hits_r;

  assign tbl_wentry.prefix = in_ch.prefix_addr;
  assign tbl_wentry.length = in_ch.route_len;
  assign tbl_wentry.hop    = in_ch.route_gw;
  assign tbl_wentry.port   = in_ch.route_port;

  assign ent = entry_t'(tbl_rdata);

  lprt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (used_r[IDX_W-1:0]),
    .wdata (tbl_wentry),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  lprt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_hits_ram (
    .clk   (clk),
    .we    (hits_we),
    .waddr (hits_waddr),
    .wdata (hits_wdata),
    .raddr (hits_raddr),
    .rdata (hits_rdata)
  );

  // match test on the entry read last cycle
  always_comb begin
    is_hit = 1'b0;
    if (rd_vld_r && active_r[eval_idx_r]) begin
      if (func_r == FUNC_DELETE) begin
        is_hit = !found_r && (ent.prefix == paddr_r) && (ent.length == plen_r);
      end else begin
        is_hit = (((dst_r ^ ent.prefix) & len_mask(ent.length)) == 32'h0) &&
                 (ent.length >= best_len_r);
      end
    end
  end

  assign scan_done = !rd_vld_r && (scan_r >= used_r);

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    active_nxt     = active_r;
    func_nxt       = func_r;
    paddr_nxt      = paddr_r;
    plen_nxt       = plen_r;
    dst_nxt        = dst_r;
    scan_nxt       = scan_r;
    rd_vld_nxt     = 1'b0;
    eval_idx_nxt   = eval_idx_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_len_nxt   = best_len_r;
    res_status_nxt = res_status_r;
    res_hop_nxt    = res_hop_r;
    res_port_nxt   = res_port_r;
    res_hits_nxt   = res_hits_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_hop_nxt    = out_hop_r;
    out_port_nxt   = out_port_r;
    out_hits_nxt   = out_hits_r;
    tbl_we         = 1'b0;
    tbl_raddr      = scan_r[IDX_W-1:0];
    hits_we        = 1'b0;
    hits_waddr     = used_r[IDX_W-1:0];
    hits_wdata     = 32'h0;
    hits_raddr     = best_r;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          func_nxt     = in_ch.func;
          paddr_nxt    = in_ch.prefix_addr;
          plen_nxt     = in_ch.route_len;
          dst_nxt      = in_ch.dst_addr;
          scan_nxt     = '0;
          found_nxt    = 1'b0;
          best_len_nxt = '0;
          res_status_nxt = STATUS_OK;
          res_hop_nxt    = 32'h0;
          res_port_nxt   = 8'h0;
          res_hits_nxt   = 32'h0;
          unique case (in_ch.func)
            FUNC_ADD: begin
              if (used_r >= CNT_W'(TABLE_DEPTH)) begin
                res_status_nxt = STATUS_FULL;
              end else begin
                tbl_we     = 1'b1;
                hits_we    = 1'b1;
                active_nxt[used_r[IDX_W-1:0]] = 1'b1;
                used_nxt   = used_r + 1'b1;
              end
              state_nxt = ST_FINISH;
            end
            FUNC_CLEAR: begin
              used_nxt   = '0;
              active_nxt = '0;
              state_nxt  = ST_FINISH;
            end
            default: begin
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_r < used_r) begin
          rd_vld_nxt   = 1'b1;
          eval_idx_nxt = scan_r[IDX_W-1:0];
          scan_nxt     = scan_r + 1'b1;
        end
        if (is_hit) begin
          found_nxt    = 1'b1;
          best_nxt     = eval_idx_r;
          best_len_nxt = ent.length;
        end
        if (scan_done) begin
          if (!found_r) begin
            res_status_nxt = STATUS_NOMATCH;
            state_nxt      = ST_FINISH;
          end else if (func_r == FUNC_DELETE) begin
            active_nxt[best_r] = 1'b0;
            state_nxt          = ST_FINISH;
          end else begin
            // fetch the winner's route and hit count
            tbl_raddr = best_r;
            state_nxt = ST_HITRD;
          end
        end
      end

      ST_HITRD: begin
        hits_we      = 1'b1;
        hits_waddr   = best_r;
        hits_wdata   = hits_rdata + 32'd1;
        res_hop_nxt  = ent.hop;
        res_port_nxt = ent.port;
        res_hits_nxt = hits_rdata + 32'd1;
        state_nxt    = ST_FINISH;
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_hop_nxt    = res_hop_r;
          out_port_nxt   = res_port_r;
          out_hits_nxt   = res_hits_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      active_r    <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      active_r    <= active_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    paddr_r      <= paddr_nxt;
    plen_r       <= plen_nxt;
    dst_r        <= dst_nxt;
    eval_idx_r   <= eval_idx_nxt;
    best_r       <= best_nxt;
    best_len_r   <= best_len_nxt;
    res_status_r <= res_status_nxt;
    res_hop_r    <= res_hop_nxt;
    res_port_r   <= res_port_nxt;
    res_hits_r   <= res_hits_nxt;
    out_status_r <= out_status_nxt;
    out_hop_r    <= out_hop_nxt;
    out_port_r   <= out_port_nxt;
    out_hits_r   <= out_hits_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count above table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.func == FUNC_CLEAR) |=> (used_r == '0) && (active_r == '0))
    else $error("clear left entries behind");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && found_r) |-> (CNT_W'(best_r) < used_r))
    else $error("best match beyond filled slots");

  a_hits_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    hits_we |-> (state_r == ST_HITRD) || (acc && in_ch.func == FUNC_ADD))
    else $error("hit count written outside add or lookup update");

  a_hit_incr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HITRD) |=> (res_hits_r == $past(hits_rdata) + 32'd1))
    else $error("hit count not incremented");

endmodule

`default_nettype wire
